@@ rtl/pcm_pkg.sv @@
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared widths, register indexes, weight types and the ratio tables of the
// height to palette colormap.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int IMAGE_SIDE = 512;

    localparam int COORD_W   = 9;
    localparam int HEIGHT_W  = 17;
    localparam int IDX_W     = 18;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_DARK   = 2'd2;

    // halving the q4.12 height leaves 13 fraction bits in s
    localparam int S_FRAC  = 13;
    localparam int WHOLE_W = HEIGHT_W - S_FRAC;

    // weights carry 16 fraction bits
    localparam int Q_FRAC  = 16;
    localparam int Q_ONE   = 65536;
    localparam int K_TENTH = 6554;

    localparam int F_W  = HEIGHT_W + 3;
    localparam int R2_W = 17;
    localparam int K_W  = 18;
    localparam int T9_W = 17;
    localparam int V1_W = 21;
    localparam int V2_W = 18;

    // weight stages plus blend stages
    localparam int PIPE_DEPTH = 9;

    typedef struct packed {
        logic signed [V1_W-1:0] v1;
        logic signed [V2_W-1:0] v2;
    } t_weights;

    // r^2 in q.16 for the magnitude of the whole count, r = 2n/15
    function automatic logic [R2_W-1:0] lut_ratio_sq(input logic [WHOLE_W-1:0] mag);
        logic [R2_W-1:0] val;
        case (mag)
            4'd0:    val = 17'd0;
            4'd1:    val = 17'd1165;
            4'd2:    val = 17'd4660;
            4'd3:    val = 17'd10485;
            4'd4:    val = 17'd18640;
            4'd5:    val = 17'd29126;
            4'd6:    val = 17'd41941;
            4'd7:    val = 17'd57087;
            4'd8:    val = 17'd74565;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

    // truncated 0.9 * r^2 term of v2, same index
    function automatic logic [T9_W-1:0] lut_ratio_term(input logic [WHOLE_W-1:0] mag);
        logic [T9_W-1:0] val;
        case (mag)
            4'd0:    val = 17'd0;
            4'd1:    val = 17'd1048;
            4'd2:    val = 17'd4193;
            4'd3:    val = 17'd9436;
            4'd4:    val = 17'd16775;
            4'd5:    val = 17'd26213;
            4'd6:    val = 17'd37746;
            4'd7:    val = 17'd51377;
            4'd8:    val = 17'd67108;
            default: val = 17'd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/pcm_pixel_if.sv @@
// ----------------------------------------------------------------------------
// pcm_pixel_if
// Pixel beat channel: coordinates and signed height, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcm_pixel_if;
    import pcm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [COORD_W-1:0]         pixel_x;
    logic [COORD_W-1:0]         pixel_y;
    logic signed [HEIGHT_W-1:0] height_value;

    modport source (output valid, output pixel_x, output pixel_y, output height_value,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input height_value,
                    output ready);
endinterface

@@ rtl/pcm_color_if.sv @@
// ----------------------------------------------------------------------------
// pcm_color_if
// Colour beat channel: linear pixel index and rgb bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcm_color_if;
    import pcm_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;

    modport source (output valid, output pixel_index, output red_out, output green_out,
                    output blue_out, input ready);
    modport sink   (input valid, input pixel_index, input red_out, input green_out,
                    input blue_out, output ready);
endinterface

@@ rtl/pcm_weight_calc.sv @@
// ----------------------------------------------------------------------------
// pcm_weight_calc
// Three stage weight path: fraction and ratio lookup, the two weight
// products, then truncation to v1 and v2.
// ----------------------------------------------------------------------------
module pcm_weight_calc (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pcm_pkg::HEIGHT_W-1:0] i_height,
    output pcm_pkg::t_weights                   o_weights
);
    import pcm_pkg::*;

    localparam int P1_W = K_W + F_W;
    localparam int P2_W = F_W + 15;
    localparam logic signed [14:0] C_TENTH = 15'(K_TENTH);

    logic               round_up;
    logic [WHOLE_W-1:0] whole_u;
    logic [WHOLE_W-1:0] whole_mag;
    logic signed [F_W-1:0] n_f;
    logic [K_W-1:0]     n_k;
    logic signed [P1_W-1:0] p1_adj;
    logic signed [P2_W-1:0] p2_adj;

    logic signed [F_W-1:0]  r_f;
    logic signed [K_W-1:0]  r_k;
    logic [T9_W-1:0]        r_t9;
    logic signed [P1_W-1:0] r_p1;
    logic signed [P2_W-1:0] r_p2;
    logic [T9_W-1:0]        r_t9_d;
    t_weights               r_weights;

    always_comb begin
        // whole count rounds toward zero
        round_up  = i_height[HEIGHT_W-1] && (|i_height[S_FRAC-1:0]);
        whole_u   = i_height[HEIGHT_W-1 -: WHOLE_W] + {{(WHOLE_W-1){1'b0}}, round_up};
        whole_mag = whole_u[WHOLE_W-1] ? (~whole_u + 1'b1) : whole_u;
        // above one the fraction is the low bits, otherwise s itself
        if (i_height > $signed(HEIGHT_W'(1 << S_FRAC))) begin
            n_f = {{WHOLE_W{1'b0}}, i_height[S_FRAC-1:0], 3'b000};
        end else begin
            n_f = {i_height, 3'b000};
        end
        n_k = K_W'(Q_ONE) - K_W'(lut_ratio_sq(whole_mag));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f  <= n_f;
            r_k  <= n_k;
            r_t9 <= lut_ratio_term(whole_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= r_k * r_f;
            r_p2   <= r_f * C_TENTH;
            r_t9_d <= r_t9;
        end
    end

    always_comb begin
        // bias negative products so the shift truncates toward zero
        p1_adj = r_p1 + (r_p1[P1_W-1] ? P1_W'(Q_ONE - 1) : P1_W'(0));
        p2_adj = r_p2 + (r_p2[P2_W-1] ? P2_W'(Q_ONE - 1) : P2_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_weights.v1 <= p1_adj[Q_FRAC +: V1_W];
            r_weights.v2 <= p2_adj[Q_FRAC +: V2_W] + {1'b0, r_t9_d};
        end
    end

    assign o_weights = r_weights;

endmodule

@@ rtl/pcm_channel_blend.sv @@
// ----------------------------------------------------------------------------
// pcm_channel_blend
// Six stage blend of one colour channel: a/b mix, dark mix, scale by 255
// and truncate to the output byte.
// ----------------------------------------------------------------------------
module pcm_channel_blend (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [pcm_pkg::CHAN_W-1:0] i_a,
    input  logic [pcm_pkg::CHAN_W-1:0] i_b,
    input  logic [pcm_pkg::CHAN_W-1:0] i_d,
    input  pcm_pkg::t_weights          i_weights,
    output logic [pcm_pkg::CHAN_W-1:0] o_chan
);
    import pcm_pkg::*;

    localparam int DIFF_W = CHAN_W + 1;
    localparam int M_W    = DIFF_W + V2_W;
    localparam int DV_W   = DIFF_W + V1_W;
    localparam int W_W    = V1_W + 1;
    localparam int BL_W   = 48;
    localparam int SC_W   = BL_W + 8;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] d_ext;
    logic [W_W-1:0]           n_w;
    logic [SC_W-1:0]          sc_adj;

    logic signed [M_W-1:0]  r_dab;
    logic [CHAN_W-1:0]      r_b;
    logic signed [DV_W-1:0] r_dv1;
    logic signed [W_W-1:0]  r_w;
    logic signed [M_W-1:0]  r_m;
    logic signed [DV_W-1:0] r_dv1_d;
    logic signed [W_W-1:0]  r_w_d;
    logic signed [BL_W-1:0] r_mw;
    logic signed [DV_W-1:0] r_dq;
    logic signed [BL_W-1:0] r_blend;
    logic signed [SC_W-1:0] r_s255;
    logic [CHAN_W-1:0]      r_chan;

    always_comb begin
        diff   = $signed({1'b0, i_a}) - $signed({1'b0, i_b});
        d_ext  = $signed({1'b0, i_d});
        n_w    = W_W'(Q_ONE) - {i_weights.v1[V1_W-1], i_weights.v1};
        // truncate toward zero on the 2^32 scale
        sc_adj = r_s255 + (r_s255[SC_W-1] ? SC_W'(33'h0_FFFF_FFFF) : SC_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // m = b + (a - b) * v2, b carried as its q.16 offset
            r_dab   <= diff * i_weights.v2;
            r_b     <= i_b;
            r_dv1   <= d_ext * i_weights.v1;
            r_w     <= n_w;

            r_m     <= $signed({{(M_W-CHAN_W-Q_FRAC){1'b0}}, r_b, {Q_FRAC{1'b0}}}) + r_dab;
            r_dv1_d <= r_dv1;
            r_w_d   <= r_w;

            r_mw    <= r_m * r_w_d;
            r_dq    <= r_dv1_d;

            r_blend <= r_mw + $signed({{(BL_W-DV_W-Q_FRAC){r_dq[DV_W-1]}}, r_dq,
                                       {Q_FRAC{1'b0}}});

            r_s255  <= {r_blend, 8'h00} - {{8{r_blend[BL_W-1]}}, r_blend};

            r_chan  <= sc_adj[2*Q_FRAC +: CHAN_W];
        end
    end

    assign o_chan = r_chan;

endmodule

@@ rtl/height_to_palette_colormap_unit.sv @@
// ----------------------------------------------------------------------------
// height_to_palette_colormap_unit
// An accepted pixel beat passes 3 weight stages, then 6 blend stages per
// channel, before it leaves as its colour beat.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// beat waits, so ready follows the output stage.
// Reset clears the valid bits and the three palette registers to zero.
// ----------------------------------------------------------------------------
module height_to_palette_colormap_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pcm_pixel_if.sink                     i_pix,
    pcm_color_if.source                   o_col,
    input  logic                          i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcm_pkg::COLOR_W-1:0]   i_cfg_data
);
    import pcm_pkg::*;

    logic             pipe_en;
    logic [IDX_W-1:0] n_idx;
    t_weights         weights;

    logic [COLOR_W-1:0]    r_color_first;
    logic [COLOR_W-1:0]    r_color_second;
    logic [COLOR_W-1:0]    r_color_dark;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [IDX_W-1:0]      r_idx [PIPE_DEPTH];

    // stall the whole line only while the last stage holds an untaken beat
    assign pipe_en     = !r_vld[PIPE_DEPTH-1] || o_col.ready;
    assign i_pix.ready = pipe_en;

    assign n_idx = IDX_W'(int'(i_pix.pixel_x) + int'(i_pix.pixel_y) * IMAGE_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_first  <= '0;
            r_color_second <= '0;
            r_color_dark   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLOR_FIRST:  r_color_first  <= i_cfg_data;
                CFG_COLOR_SECOND: r_color_second <= i_cfg_data;
                CFG_COLOR_DARK:   r_color_dark   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_idx[0] <= n_idx;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_idx[i] <= r_idx[i-1];
            end
        end
    end

    pcm_weight_calc u_weight (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_height  (i_pix.height_value),
        .o_weights (weights)
    );

    pcm_channel_blend u_blend_red (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_a       (r_color_first[23:16]),
        .i_b       (r_color_second[23:16]),
        .i_d       (r_color_dark[23:16]),
        .i_weights (weights),
        .o_chan    (o_col.red_out)
    );

    pcm_channel_blend u_blend_green (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_a       (r_color_first[15:8]),
        .i_b       (r_color_second[15:8]),
        .i_d       (r_color_dark[15:8]),
        .i_weights (weights),
        .o_chan    (o_col.green_out)
    );

    pcm_channel_blend u_blend_blue (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_a       (r_color_first[7:0]),
        .i_b       (r_color_second[7:0]),
        .i_d       (r_color_dark[7:0]),
        .i_weights (weights),
        .o_chan    (o_col.blue_out)
    );

    assign o_col.valid       = r_vld[PIPE_DEPTH-1];
    assign o_col.pixel_index = r_idx[PIPE_DEPTH-1];

endmodule
